// ===== hdl/point_intensity_max_raster_core_assert.svh =====
// assertion macros for the raster core checker
`ifndef POINT_INTENSITY_MAX_RASTER_CORE_ASSERT_SVH
`define POINT_INTENSITY_MAX_RASTER_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PIMR_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication with the consequent checked in the following cycle
`define PIMR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/pimr_pkg.sv =====
// ----------------------------------------------------------------------------
// pimr_pkg
// shared types and constants of the intensity raster core
// ----------------------------------------------------------------------------
package pimr_pkg;
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] REG_LEFT_X = 3'd0;
    localparam logic [2:0] REG_TOP_Y  = 3'd1;
    localparam logic [2:0] REG_INV    = 3'd2;
    localparam logic [2:0] REG_ROWS   = 3'd3;
    localparam logic [2:0] REG_COLS   = 3'd4;
    localparam logic [2:0] REG_FULL   = 3'd5;

    localparam int GREY_FULL = 255;

    typedef struct packed {
        logic        opcode;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [15:0] point_intensity;
        logic [7:0]  read_row;
        logic [7:0]  read_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] cell_intensity;
        logic        cell_hit;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic take_in;     // register the input item
        logic mul_go;      // compute coordinates
        logic rd_go;       // issue ram read
        logic wr_go;       // write back
        logic div_start;   // start pixel divide
        logic out_load;    // load result
        logic clr_step;    // clearing pass write
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic in_range;
        logic div_done;
        logic clr_last;
    } dp_stat_t;
endpackage

// ===== hdl/pimr_if.sv =====
// ----------------------------------------------------------------------------
// pimr_in_if / pimr_out_if
// valid ready channels for input and result items
// ----------------------------------------------------------------------------
interface pimr_in_if;
    import pimr_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pimr_out_if;
    import pimr_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pimr_ram.sv =====
// ----------------------------------------------------------------------------
// pimr_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module pimr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

// ===== hdl/pimr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pimr_ctrl
// sequencer for clearing pass, accumulate and read items
// ----------------------------------------------------------------------------
module pimr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pimr_pkg::dp_stat_t stat,
    output pimr_pkg::dp_cmd_t  cmd
);
    import pimr_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    assign out_valid = ovalid_reg;
    // one item in flight, a new item is taken only in idle
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (stat.is_read || stat.in_range)
                begin
                    cmd.rd_go  = 1'b1;
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MOD:
            begin
                if (!stat.is_read)
                begin
                    cmd.wr_go  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!ovalid_next)
                begin
                    cmd.wr_go     = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

// ===== hdl/pimr_dp.sv =====
// ----------------------------------------------------------------------------
// pimr_dp
// coordinate math, cell store access and pixel divider
// ----------------------------------------------------------------------------
module pimr_dp #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pimr_pkg::dp_cmd_t   cmd,
    output pimr_pkg::dp_stat_t  stat,
    input  pimr_pkg::in_item_t  in_data,
    output pimr_pkg::out_item_t out_data,
    input  logic [31:0]         left_x,
    input  logic [31:0]         top_y,
    input  logic [23:0]         inv_cell,
    input  logic [8:0]          rows_use,
    input  logic [8:0]          cols_use,
    input  logic [15:0]         full_scale
);
    import pimr_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(4096 + 1);

    in_item_t         item_reg;
    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    col_reg;
    logic             range_reg;
    logic [AW-1:0]    clr_reg;
    logic [15:0]      cell_reg;
    logic [23:0]      num_reg;
    logic [15:0]      rem_reg;
    logic [8:0]       quo_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    out_item_t        out_reg;

    logic [32:0] dy, dx;
    logic [56:0] prod_r, prod_c;
    logic [32:0] crow, ccol;
    logic [NW-1:0] nrows, ncols;
    logic        ok_r, ok_c;
    logic [AW-1:0] addr;
    logic [15:0] rdata, wdata;
    logic        we;
    logic [16:0] trial;

    always_comb
    begin
        dy = {top_y[31], top_y} - {item_reg.point_y[31], item_reg.point_y};
        dx = {item_reg.point_x[31], item_reg.point_x} - {left_x[31], left_x};
        prod_r = {24'd0, dy[32] ? 33'd0 : dy} * {33'd0, inv_cell};
        prod_c = {24'd0, dx[32] ? 33'd0 : dx} * {33'd0, inv_cell};
        crow = prod_r[56:24];
        ccol = prod_c[56:24];
        nrows = (NW'(rows_use) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(rows_use);
        ncols = (NW'(cols_use) > NW'(MAX_COLS)) ? NW'(MAX_COLS) : NW'(cols_use);
        ok_r = !(dy[32] && inv_cell != 24'd0) && (crow < {{(33-NW){1'b0}}, nrows});
        ok_c = !(dx[32] && inv_cell != 24'd0) && (ccol < {{(33-NW){1'b0}}, ncols});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            item_reg <= in_data;
        end
        if (cmd.mul_go)
        begin
            if (item_reg.opcode == OP_READ)
            begin
                range_reg <= (32'(item_reg.read_row) < MAX_ROWS)
                          && (32'(item_reg.read_col) < MAX_COLS);
                row_reg <= RW'(item_reg.read_row);
                col_reg <= CW'(item_reg.read_col);
            end
            else
            begin
                range_reg <= ok_r && ok_c;
                row_reg   <= RW'(crow);
                col_reg   <= CW'(ccol);
            end
        end
    end

    // the 57 bit prods fit one multiplier each, 33x24 bits
    assign addr = cmd.clr_step ? clr_reg
                : AW'(32'(row_reg) * MAX_COLS + 32'(col_reg));
    assign we = cmd.clr_step || (cmd.wr_go && range_reg);
    assign wdata = cmd.clr_step ? 16'd0
                 : (item_reg.opcode == OP_READ) ? 16'd0
                 : ((item_reg.point_intensity > rdata) ? item_reg.point_intensity : rdata);

    pimr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .re    (cmd.rd_go),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.div_start)
            begin
                busy_reg <= (full_scale != 16'd0) && (range_reg && rdata != 16'd0);
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // restoring divide of cell*255 by full scale, one bit a cycle
    // quotient bit 8 sticks once the quotient passes 255
    assign trial = {rem_reg, num_reg[23]} - {1'b0, full_scale};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            cell_reg <= range_reg ? rdata : 16'd0;
            num_reg  <= range_reg ? ({8'd0, rdata} * 24'd255) : 24'd0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[22:0], 1'b0};
            if (!trial[16])
            begin
                rem_reg <= trial[15:0];
                quo_reg <= (quo_reg[8]) ? quo_reg : {quo_reg[7:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[14:0], num_reg[23]};
                quo_reg <= (quo_reg[8]) ? quo_reg : {quo_reg[7:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            out_reg.cell_intensity <= cell_reg;
            out_reg.cell_hit       <= (cell_reg != 16'd0);
            out_reg.pixel_value    <= (cell_reg == 16'd0) ? 8'd0
                                    : (full_scale == 16'd0 || quo_reg[8]) ? 8'(GREY_FULL)
                                    : quo_reg[7:0];
        end
    end

    assign out_data       = out_reg;
    assign stat.is_read   = (item_reg.opcode == OP_READ);
    assign stat.in_range  = range_reg;
    assign stat.div_done  = !busy_reg && !cmd.div_start;
    assign stat.clr_last  = (clr_reg == AW'(DEPTH - 1));
endmodule

// ===== hdl/point_intensity_max_raster_core.sv =====
// ----------------------------------------------------------------------------
// point_intensity_max_raster_core
// max intensity rasterizer for lidar points with read and clear
// ----------------------------------------------------------------------------
// accumulate item: multiply, ram read, write back
// read item: multiply, ram read, 24 divide steps for a nonzero cell, none for an empty cell
// one item in flight; results wait in an output register, valid in the cycle after the load
// reset clears registers and then sweeps all MAX_ROWS*MAX_COLS cells of the cell
// ram with no item accepted; apb writes are taken during the sweep
module point_intensity_max_raster_core #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    pimr_in_if.sink     in_ch,
    pimr_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pimr_pkg::*;

    logic [31:0] left_reg, top_reg;
    logic [23:0] inv_reg;
    logic [8:0]  rows_reg, cols_reg;
    logic [15:0] full_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    // register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            top_reg  <= '0;
            inv_reg  <= 24'd65536;
            rows_reg <= 9'd256;
            cols_reg <= 9'd256;
            full_reg <= 16'hffff;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            unique case (ridx)
                REG_LEFT_X: left_reg <= pwdata;
                REG_TOP_Y:  top_reg  <= pwdata;
                REG_INV:    inv_reg  <= pwdata[23:0];
                REG_ROWS:   rows_reg <= pwdata[8:0];
                REG_COLS:   cols_reg <= pwdata[8:0];
                REG_FULL:   full_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (ridx)
            REG_LEFT_X: prdata = left_reg;
            REG_TOP_Y:  prdata = top_reg;
            REG_INV:    prdata = {8'd0, inv_reg};
            REG_ROWS:   prdata = {23'd0, rows_reg};
            REG_COLS:   prdata = {23'd0, cols_reg};
            REG_FULL:   prdata = {16'd0, full_reg};
            default:    prdata = '0;
        endcase
    end

    pimr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pimr_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (in_ch.data),
        .out_data   (out_ch.data),
        .left_x     (left_reg),
        .top_y      (top_reg),
        .inv_cell   (inv_reg),
        .rows_use   (rows_reg),
        .cols_use   (cols_reg),
        .full_scale (full_reg)
    );
endmodule

// ===== hdl/pimr_checker.sv =====
// ----------------------------------------------------------------------------
// pimr_checker
// port level checks of the raster core
// ----------------------------------------------------------------------------
`include "point_intensity_max_raster_core_assert.svh"
module pimr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       hit,
    input logic [15:0] cell_int,
    input logic [7:0] pix,
    input logic       pready
);
    `PIMR_ASSERT_IMP(a_hit, clk, rst_n, out_valid, hit == (cell_int != 16'd0))
    `PIMR_ASSERT_IMP(a_empty, clk, rst_n, out_valid && !hit, pix == 8'd0)
    `PIMR_ASSERT_NEXT(a_one, clk, rst_n, in_valid && in_ready, !in_ready)
    `PIMR_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PIMR_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)
endmodule

bind point_intensity_max_raster_core pimr_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .hit       (out_ch.data.cell_hit),
    .cell_int  (out_ch.data.cell_intensity),
    .pix       (out_ch.data.pixel_value),
    .pready    (pready)
);
